/* rtl/core/ntsr_pkg.sv */
package ntsr_pkg;

   localparam int SLOT_COUNT   = 3;
   localparam int SCAN_LENGTH  = 4096;

   localparam int RANGE_W      = 16;
   localparam int INDEX_W      = 12;
   localparam int RANK_W       = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 2;

   localparam int REQ_TDATA_W  = 32;
   localparam int RSP_TDATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_FIRST   = 2'd0,
      CSR_WINDOW_LAST    = 2'd1,
      CSR_MIN_SEPARATION = 2'd2,
      CSR_EMPTY_RANGE    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [RANGE_W-1:0] range;
   } slot_type;

   typedef slot_type [SLOT_COUNT-1:0] slot_set_type;

   typedef struct packed {
      logic [INDEX_W-1:0] window_first;
      logic [INDEX_W-1:0] window_last;
      logic [INDEX_W-1:0] min_separation;
   } window_cfg_type;

endpackage

/* rtl/core/ntsr_examine.sv */
module ntsr_examine
   import ntsr_pkg::*;
(
   input  slot_set_type        slots,
   input  logic [RANGE_W-1:0]  sample_range,
   input  logic [INDEX_W-1:0]  sample_index,
   input  window_cfg_type      cfg,
   output slot_set_type        slots_next
);

   logic               in_window;
   logic               sep0;
   logic               sep1;
   logic [INDEX_W-1:0] dist0;
   logic [INDEX_W-1:0] dist1;
   slot_type           sample;

   assign sample = '{index: sample_index, range: sample_range};

   assign in_window = (sample_index >= cfg.window_first) &&
                      (sample_index <= cfg.window_last) &&
                      (32'(sample_index) < 32'(SCAN_LENGTH));

   assign dist0 = (sample_index > slots[0].index) ? sample_index - slots[0].index
                                                  : slots[0].index - sample_index;
   assign dist1 = (sample_index > slots[1].index) ? sample_index - slots[1].index
                                                  : slots[1].index - sample_index;
   assign sep0  = dist0 > cfg.min_separation;
   assign sep1  = dist1 > cfg.min_separation;

   always_comb begin
      slots_next = slots;
      if (in_window) begin
         if (sample_range < slots[0].range) begin
            // nearer than best: push down only if clear of best, else overwrite
            if (sep0) begin
               slots_next[2] = slots[1];
               slots_next[1] = slots[0];
            end
            slots_next[0] = sample;
         end else if (sample_range < slots[1].range) begin
            if (sep0 && sep1) begin
               slots_next[2] = slots[1];
            end
            if (sep0) begin
               slots_next[1] = sample;
            end
         end else if (sample_range < slots[2].range) begin
            if (sep0 && sep1) begin
               slots_next[2] = sample;
            end
         end
      end
   end

endmodule

/* rtl/core/nearest_three_separated_returns_core.sv */
// Nearest three separated returns. Scanner samples stream in on req_ one per
// transaction and are registered, then compared against three ranked slots in
// the following cycle. A sample inside the index window that is nearer than a
// slot and clear of the better slots by more than min_separation takes that
// slot; a sample nearer than the best but too close to it overwrites the best
// in place. The sample flagged with tlast ends the scan: it is examined, the
// three slots are copied to a report buffer and cleared to empty_range with
// index 0. The report leaves on rsp_ as three transactions, rank 0 first, with
// tlast on rank 2. One sample is taken every clock unless a scan end stalls: a
// second scan end waits only until the previous three-transaction report has
// drained from the report buffer. Configuration is written through csr_; the
// user must write it only while the block is idle, as the block itself does
// not enforce this.
module nearest_three_separated_returns_core
   import ntsr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [15:0] range_sample, [27:16] sample_index, [31:28] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tlast,       // end_of_scan

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [1:0] slot_rank, [13:2] slot_index, [29:14] slot_range, [31:30] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,       // last_of_run

   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   window_cfg_type     cfg_ff;
   logic [RANGE_W-1:0] empty_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_first   <= '0;
         cfg_ff.window_last    <= INDEX_W'(SCAN_LENGTH - 1);
         cfg_ff.min_separation <= INDEX_W'(10);
         empty_range_ff        <= '1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_FIRST:   cfg_ff.window_first   <= csr_wdata[INDEX_W-1:0];
            CSR_WINDOW_LAST:    cfg_ff.window_last    <= csr_wdata[INDEX_W-1:0];
            CSR_MIN_SEPARATION: cfg_ff.min_separation <= csr_wdata[INDEX_W-1:0];
            CSR_EMPTY_RANGE:    empty_range_ff        <= csr_wdata[RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   // input register stage
   logic               s1_valid_ff;
   logic [RANGE_W-1:0] s1_range_ff;
   logic [INDEX_W-1:0] s1_index_ff;
   logic               s1_eos_ff;
   logic               s1_adv;
   logic               req_fire;

   // report buffer: shifts down as each transaction is taken
   slot_set_type       rpt_ff;
   slot_set_type       rpt_in;
   logic [RANK_W-1:0]  rpt_rank_ff;
   logic               rpt_busy_ff;
   logic               rpt_last;
   logic               rpt_free;
   logic               rsp_fire;

   // ranked slots
   slot_set_type       slot_ff;
   slot_set_type       slot_in;
   slot_set_type       slot_examined;

   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign rpt_last = rpt_rank_ff == RANK_W'(SLOT_COUNT - 1);
   assign rpt_free = !rpt_busy_ff || (rsp_tready && rpt_last);

   // a scan end may only move on once the report buffer is free
   assign s1_adv     = s1_valid_ff && (!s1_eos_ff || rpt_free);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_range_ff <= req_tdata[RANGE_W-1:0];
         s1_index_ff <= req_tdata[RANGE_W+INDEX_W-1:RANGE_W];
         s1_eos_ff   <= req_tlast;
      end
   end

   ntsr_examine u_examine (
      .slots        (slot_ff),
      .sample_range (s1_range_ff),
      .sample_index (s1_index_ff),
      .cfg          (cfg_ff),
      .slots_next   (slot_examined)
   );

   always_comb begin
      slot_in = slot_ff;
      if (s1_adv) begin
         if (s1_eos_ff) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               slot_in[i] = '{index: '0, range: empty_range_ff};
            end
         end else begin
            slot_in = slot_examined;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_ff[i] <= '{index: '0, range: '1};
         end
      end else begin
         slot_ff <= slot_in;
      end
   end

   always_comb begin
      rpt_in = rpt_ff;
      if (s1_adv && s1_eos_ff) begin
         rpt_in = slot_examined;
      end else if (rsp_fire) begin
         for (int i = 0; i < SLOT_COUNT - 1; i++) begin
            rpt_in[i] = rpt_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      rpt_ff <= rpt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rpt_busy_ff <= 1'b0;
         rpt_rank_ff <= '0;
      end else if (s1_adv && s1_eos_ff) begin
         rpt_busy_ff <= 1'b1;
         rpt_rank_ff <= '0;
      end else if (rsp_fire) begin
         if (rpt_last) begin
            rpt_busy_ff <= 1'b0;
            rpt_rank_ff <= '0;
         end else begin
            rpt_rank_ff <= rpt_rank_ff + RANK_W'(1);
         end
      end
   end

   assign rsp_tvalid = rpt_busy_ff;
   assign rsp_tlast  = rpt_last;
   assign rsp_tdata  = {{(RSP_TDATA_W - RANK_W - INDEX_W - RANGE_W){1'b0}},
                        rpt_ff[0].range, rpt_ff[0].index, rpt_rank_ff};

   // checks
   a_last_on_top_rank : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[RANK_W-1:0] == RANK_W'(SLOT_COUNT - 1))
      else $error("tlast on a report transaction that is not the top rank");

   a_report_continues : assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_tlast |=> rsp_tvalid &&
         rsp_tdata[RANK_W-1:0] == $past(rsp_tdata[RANK_W-1:0]) + RANK_W'(1))
      else $error("report broken off before its last rank");

   a_stall_only_on_busy : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |-> s1_eos_ff && rpt_busy_ff)
      else $error("input stage stalled without a pending report");

   a_clear_after_scan : assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_eos_ff |=> slot_ff[0].range == $past(empty_range_ff) &&
         slot_ff[0].index == '0 && rsp_tvalid)
      else $error("slots not cleared or report not raised after scan end");

endmodule
